// ----- rtl/i2cms_pkg.sv -----
// Types, codes and the segment step function of the I2C master byte sequencer.
package i2cms_pkg;

  localparam logic [7:0] LIMIT_RESET   = 8'd250;
  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_SEND  = 3'd2;
  localparam logic [2:0] FUNC_WAIT  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_WAIT  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       dir;
    logic [7:0] tmo;
    logic       ack_flag;
    logic [1:0] hold;
    logic       ack_sel;
    logic [7:0] rx_hold;
  } seq_st_t;

  typedef struct packed {
    seq_st_t    s;
    logic [2:0] dly;
    logic       fin;
  } seg_res_t;

  typedef struct packed {
    seq_st_t s;
    logic    done;
  } adv_res_t;

  // One pin segment: new state and hold in ticks (fin ends the command).
  function automatic seg_res_t seg_run(seq_st_t s, logic sda_in, logic [7:0] lim);
    seg_res_t   r;
    logic [3:0] bi;
    r     = '{s: s, dly: 3'd0, fin: 1'b0};
    bi    = s.bit_idx + 4'd1;
    unique case (s.op)
      OP_START: begin
        if (s.phase == 4'd0) begin
          r.s.dir = 1'b1; r.s.sda = 1'b1; r.s.scl = 1'b1; r.s.phase = 4'd1; r.dly = 3'd4;
        end else if (s.phase == 4'd1) begin
          r.s.sda = 1'b0; r.s.phase = 4'd2; r.dly = 3'd4;
        end else begin
          r.s.scl = 1'b0; r.fin = 1'b1;
        end
      end
      OP_STOP: begin
        if (s.phase == 4'd0) begin
          r.s.dir = 1'b1; r.s.scl = 1'b0; r.s.sda = 1'b0; r.s.phase = 4'd1; r.dly = 3'd4;
        end else if (s.phase == 4'd1) begin
          r.s.scl = 1'b1; r.s.phase = 4'd2; r.dly = 3'd4;
        end else if (s.phase == 4'd2) begin
          r.s.sda = 1'b1; r.s.phase = 4'd3; r.dly = 3'd4;
        end else begin
          r.fin = 1'b1;
        end
      end
      OP_WAIT: begin
        if (s.phase == 4'd0) begin
          r.s.dir = 1'b0; r.s.scl = 1'b0; r.s.sda = 1'b1; r.s.phase = 4'd1; r.dly = 3'd1;
        end else if (s.phase == 4'd1) begin
          r.s.scl = 1'b1; r.s.phase = 4'd2; r.dly = 3'd1;
        end else if (s.phase == 4'd2) begin
          if (!sda_in) begin
            r.s.phase = 4'd3;
          end else if (s.tmo >= lim) begin
            r.s.ack_flag = 1'b1; r.s.op = OP_STOP; r.s.phase = 4'd0;
          end else begin
            r.s.tmo = s.tmo + 8'd1; r.dly = 3'd1;
          end
        end else if (s.phase == 4'd3) begin
          r.s.scl = 1'b0; r.s.phase = 4'd4; r.dly = 3'd1;
        end else begin
          r.fin = 1'b1;
        end
      end
      OP_SEND: begin
        if (s.phase == 4'd0) begin
          r.s.dir = 1'b1; r.s.scl = 1'b0; r.s.bit_idx = 4'd0; r.s.phase = 4'd1;
        end else if (s.phase == 4'd1) begin
          r.s.sda   = |(s.shift & MSB_MASK);
          r.s.shift = {s.shift[6:0], 1'b0};
          r.s.phase = 4'd2; r.dly = 3'd2;
        end else if (s.phase == 4'd2) begin
          r.s.scl = 1'b1; r.s.phase = 4'd3; r.dly = 3'd2;
        end else if (s.phase == 4'd3) begin
          r.s.scl = 1'b0; r.s.bit_idx = bi;
          r.s.phase = (bi >= BITS_PER_BYTE) ? 4'd4 : 4'd1;
          r.dly = 3'd2;
        end else begin
          r.fin = 1'b1;
        end
      end
      OP_READ: begin
        if (s.phase == 4'd0) begin
          r.s.dir = 1'b0; r.s.bit_idx = 4'd0; r.s.phase = 4'd1;
        end else if (s.phase == 4'd1) begin
          r.s.scl = 1'b0; r.s.phase = 4'd2; r.dly = 3'd2;
        end else if (s.phase == 4'd2) begin
          r.s.scl = 1'b1; r.s.shift = {s.shift[6:0], sda_in}; r.s.bit_idx = bi;
          r.s.phase = (bi >= BITS_PER_BYTE) ? 4'd3 : 4'd1;
          r.dly = 3'd1;
        end else if (s.phase == 4'd3) begin
          r.s.scl = 1'b0; r.s.dir = 1'b1; r.s.sda = ~s.ack_sel; r.s.phase = 4'd4;
          r.dly = 3'd2;
        end else if (s.phase == 4'd4) begin
          r.s.scl = 1'b1; r.s.phase = 4'd5; r.dly = 3'd2;
        end else begin
          r.s.scl = 1'b0; r.s.rx_hold = s.shift; r.fin = 1'b1;
        end
      end
      default: r.fin = 1'b1;
    endcase
    return r;
  endfunction

  // Applies the hold or the end of a segment to the state.
  function automatic adv_res_t seg_close(seg_res_t r);
    adv_res_t   a;
    logic [2:0] h;
    a = '{s: r.s, done: 1'b0};
    h = r.dly - 3'd1;
    if (r.fin) begin
      a.s.op = OP_IDLE; a.s.phase = 4'd0; a.s.hold = 2'd0; a.done = 1'b1;
    end else if (r.dly != 3'd0) begin
      a.s.hold = h[1:0];
    end
    return a;
  endfunction

  // Zero-hold segments chain at most twice within one tick.
  function automatic adv_res_t advance(seq_st_t s, logic sda_in, logic [7:0] lim);
    seg_res_t r1;
    seg_res_t r2;
    r1 = seg_run(s, sda_in, lim);
    r2 = seg_run(r1.s, sda_in, lim);
    if (r1.fin || r1.dly != 3'd0) begin
      return seg_close(r1);
    end
    return seg_close(r2);
  endfunction

endpackage

// ----- rtl/i2cms_if.sv -----
// Channel interfaces: command/pin input, pin/status result and configuration write.
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;
  modport source (output valid, cmd_valid, func, tx_byte, send_ack, sda_in, input ready);
  modport sink (input valid, cmd_valid, func, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;
  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_failed, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                rx_byte, ack_failed, output ready);
endinterface

interface i2cms_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/i2cms_engine.sv -----
// Sequencer state registers and the per-tick update of pins and status.
module i2cms_engine
  import i2cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  item_t      item,
  input  logic [7:0] lim,
  output result_t    res
);

  seq_st_t  st_r;
  seq_st_t  st_nxt;
  seq_st_t  st_go;
  adv_res_t adv_a;
  adv_res_t adv_b;
  logic     done;
  logic     start_ok;

  assign start_ok = item.cmd_valid && (item.func <= FUNC_READ);

  always_comb begin
    st_go       = st_r;
    st_go.phase = 4'd0;
    st_go.hold  = 2'd0;
    unique case (item.func)
      FUNC_START: st_go.op = OP_START;
      FUNC_STOP:  st_go.op = OP_STOP;
      FUNC_SEND: begin
        st_go.op    = OP_SEND;
        st_go.shift = item.tx_byte;
      end
      FUNC_WAIT: begin
        st_go.op       = OP_WAIT;
        st_go.tmo      = 8'd0;
        st_go.ack_flag = 1'b0;
      end
      FUNC_READ: begin
        st_go.op      = OP_READ;
        st_go.ack_sel = item.send_ack;
      end
      default: st_go.op = OP_IDLE;
    endcase
  end

  assign adv_a = advance(st_go, item.sda_in, lim);
  assign adv_b = advance(st_r, item.sda_in, lim);

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    if (st_r.op == OP_IDLE) begin
      if (start_ok) begin
        st_nxt = adv_a.s;
        done   = adv_a.done;
      end
    end else if (st_r.hold != 2'd0) begin
      st_nxt.hold = st_r.hold - 2'd1;
    end else begin
      st_nxt = adv_b.s;
      done   = adv_b.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{op: OP_IDLE, phase: 4'd0, bit_idx: 4'd0, shift: 8'd0, scl: 1'b1,
                sda: 1'b1, dir: 1'b1, tmo: 8'd0, ack_flag: 1'b0, hold: 2'd0,
                ack_sel: 1'b0, rx_hold: 8'd0};
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign res.scl_level  = st_nxt.scl;
  assign res.sda_level  = st_nxt.sda;
  assign res.sda_drive  = st_nxt.dir;
  assign res.busy_res   = (st_nxt.op != OP_IDLE);
  assign res.done_res   = done;
  assign res.rx_byte    = st_nxt.rx_hold;
  assign res.ack_failed = st_nxt.ack_flag;

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && st_r.op == OP_IDLE && !start_ok |=> st_r.op == OP_IDLE)
    else $error("idle sequencer left idle without a command");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hold != 2'd0 |-> st_r.op != OP_IDLE)
    else $error("hold count pending while idle");

  a_flag_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.ack_flag) |-> $past(st_r.op) == OP_WAIT)
    else $error("ack failure raised outside an ack wait");

  a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(st_r))
    else $error("state moved without a tick");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_idx <= BITS_PER_BYTE)
    else $error("bit index beyond a byte");

endmodule

// ----- rtl/i2c_master_byte_sequencer.sv -----
// Top level of the I2C master byte sequencer: channel registers and config register.
//
// Each transaction on in_chan is one 1 us tick: an optional command (start, stop,
// send byte, wait for ack, read byte with ack or nack) and the sampled SDA level.
// Each tick yields exactly one transaction on out_chan with the SCL level, SDA level
// and direction, busy, a done pulse, the last read byte and the ack-failure flag.
// cfg_chan writes the ack timeout limit (reset 250); it is always ready; the user
// must write it only while no tick is in flight, which the block does not enforce.
// A tick passes the input register, then one pass through the pin sequencer into
// the output register, before it is offered on out_chan.
// Throughput: one tick per cycle while out_chan does not stall; the sequencer state updates once per tick.
// When out_chan stalls, the output register holds and the input register fills,
// then in_chan.ready drops; no tick is lost or repeated.
// Reset (rst_n low, synchronous): sequencer idle, SCL and SDA high, SDA driven,
// counters, flags and the received byte cleared, both channel stages empty.
module i2c_master_byte_sequencer
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cms_in_if.sink    in_chan,
  i2cms_out_if.source out_chan,
  i2cms_cfg_if.sink   cfg_chan
);

  item_t      item_r;
  logic       item_vld_r;
  result_t    res;
  result_t    res_r;
  logic       res_vld_r;
  logic [7:0] lim_r;
  logic       out_load;
  logic       step_en;
  logic       in_take;

  assign out_load = !res_vld_r || out_chan.ready;
  assign step_en  = item_vld_r && out_load;
  assign in_chan.ready = !item_vld_r || out_load;
  assign in_take  = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      lim_r      <= LIMIT_RESET;
    end else begin
      if (in_take) begin
        item_vld_r <= 1'b1;
      end else if (step_en) begin
        item_vld_r <= 1'b0;
      end
      if (step_en) begin
        res_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        res_vld_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        lim_r <= cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{cmd_valid: in_chan.cmd_valid, func: in_chan.func,
                  tx_byte: in_chan.tx_byte, send_ack: in_chan.send_ack,
                  sda_in: in_chan.sda_in};
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  i2cms_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .lim     (lim_r),
    .res     (res)
  );

  assign out_chan.valid      = res_vld_r;
  assign out_chan.scl_level  = res_r.scl_level;
  assign out_chan.sda_level  = res_r.sda_level;
  assign out_chan.sda_drive  = res_r.sda_drive;
  assign out_chan.busy_res   = res_r.busy_res;
  assign out_chan.done_res   = res_r.done_res;
  assign out_chan.rx_byte    = res_r.rx_byte;
  assign out_chan.ack_failed = res_r.ack_failed;

endmodule
